@@ sv/idt_pkg.sv @@
// Shared constants, item types and controller/datapath interface types.
package idt_pkg;

    localparam int NUM_REGS   = 256;
    localparam int MAX_LOADS  = 16;
    localparam int LABEL_BITS = 12;

    localparam int REG_IW    = $clog2(NUM_REGS);
    localparam int LD_IW     = (MAX_LOADS > 1) ? $clog2(MAX_LOADS) : 1;
    localparam int LD_CW     = $clog2(MAX_LOADS + 1);
    localparam int MAX_EDGES = MAX_LOADS + 3;
    localparam int LABEL_MAX = (1 << LABEL_BITS) - 1;

    localparam logic [3:0] OP_NOP    = 4'd0;
    localparam logic [3:0] OP_LOAD   = 4'd1;
    localparam logic [3:0] OP_LOADI  = 4'd2;
    localparam logic [3:0] OP_STORE  = 4'd3;
    localparam logic [3:0] OP_ADD    = 4'd4;
    localparam logic [3:0] OP_RSHIFT = 4'd8;
    localparam logic [3:0] OP_OUTPUT = 4'd9;

    typedef struct packed {
        logic       block_start;
        logic [3:0] operation;
        logic       src1_is_reg;
        logic [7:0] src1_reg;
        logic       src2_is_reg;
        logic [7:0] src2_reg;
        logic       dest_present;
        logic [7:0] dest_reg;
    } t_in_item;

    typedef struct packed {
        logic [11:0] node_label;
        logic        has_edge;
        logic [11:0] predecessor_label;
        logic        last_of_run;
        logic        load_list_overflow;
        logic        label_overflow;
    } t_out_item;

    // Which candidate predecessor the datapath examines this cycle.
    typedef enum logic [1:0] {
        CS_RD   = 2'd0,  // definer read from the register table
        CS_LOUT = 2'd1,  // last output
        CS_LST  = 2'd2,  // last store
        CS_LOAD = 2'd3   // pending load under the walk pointer
    } t_cand_sel;

    typedef struct packed {
        logic      accept;
        logic      label;
        logic      rd1;
        logic      rd2;
        logic      wr_dest;
        logic      cand_en;
        t_cand_sel cand_sel;
        logic      walk_clr;
        logic      walk_inc;
        logic      finish;
    } t_cmd;

    typedef struct packed {
        logic in_nop;
        logic out_free;
        logic walk_more;
    } t_sts;

    function automatic logic reg_ok(input logic [7:0] r);
        reg_ok = (int'(r) < NUM_REGS);
    endfunction

    function automatic logic [REG_IW-1:0] reg_idx(input logic [7:0] r);
        reg_idx = REG_IW'(r);
    endfunction

endpackage

@@ sv/idt_ctrl.sv @@
// Sequencer: steps one instruction through lookups, serialization checks and the load walk.
module idt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  idt_pkg::t_sts i_sts,
    output idt_pkg::t_cmd o_cmd,
    output logic          o_in_stall
);
    import idt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LABEL,
        S_C1,
        S_C2,
        S_LO,
        S_LS,
        S_LD,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.cand_sel = CS_RD;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (!i_sts.in_nop) begin
                        n_state = S_LABEL;
                    end
                end
            end
            S_LABEL: begin
                o_cmd.label = 1'b1;
                o_cmd.rd1   = 1'b1;
                n_state     = S_C1;
            end
            S_C1: begin
                if (i_sts.out_free) begin
                    o_cmd.cand_en = 1'b1;
                    o_cmd.rd2     = 1'b1;
                    n_state       = S_C2;
                end
            end
            S_C2: begin
                if (i_sts.out_free) begin
                    o_cmd.cand_en = 1'b1;
                    o_cmd.wr_dest = 1'b1;
                    n_state       = S_LO;
                end
            end
            S_LO: begin
                o_cmd.cand_sel = CS_LOUT;
                if (i_sts.out_free) begin
                    o_cmd.cand_en = 1'b1;
                    n_state       = S_LS;
                end
            end
            S_LS: begin
                o_cmd.cand_sel = CS_LST;
                if (i_sts.out_free) begin
                    o_cmd.cand_en  = 1'b1;
                    o_cmd.walk_clr = 1'b1;
                    n_state        = S_LD;
                end
            end
            S_LD: begin
                o_cmd.cand_sel = CS_LOAD;
                if (!i_sts.walk_more) begin
                    n_state = S_FIN;
                end else if (i_sts.out_free) begin
                    o_cmd.cand_en  = 1'b1;
                    o_cmd.walk_inc = 1'b1;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

@@ sv/idt_datapath.sv @@
// Tables, label counter, duplicate filter and result register.
module idt_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  idt_pkg::t_in_item  i_in_data,
    input  logic               i_out_stall,
    input  idt_pkg::t_cmd      i_cmd,
    output idt_pkg::t_sts      o_sts,
    output logic               o_out_valid,
    output idt_pkg::t_out_item o_out_data
);
    import idt_pkg::*;

    // control state
    logic                  r_def_v [NUM_REGS];
    logic [LABEL_BITS:0]   r_next;
    logic                  r_lo_v;
    logic                  r_ls_v;
    logic [LD_CW-1:0]      r_ld_cnt;
    logic                  r_seen_v [MAX_EDGES];
    logic                  r_hold_v;
    logic                  r_out_v;

    // payload state
    t_in_item              r_item;
    logic [LABEL_BITS-1:0] r_mem [NUM_REGS];
    logic [LABEL_BITS-1:0] r_rdata;
    logic                  r_rv;
    logic [LABEL_BITS-1:0] r_label;
    logic                  r_lbl_ovf;
    logic                  r_ld_ovf;
    logic [LABEL_BITS-1:0] r_lo;
    logic [LABEL_BITS-1:0] r_ls;
    logic [LABEL_BITS-1:0] r_loads [MAX_LOADS];
    logic [LABEL_BITS-1:0] r_seen [MAX_EDGES];
    logic [LABEL_BITS-1:0] r_hold;
    logic [LD_CW-1:0]      r_li;
    t_out_item             r_out;

    logic                  is_ld, is_ldi, is_st, is_alu, is_out;
    logic                  use1, use2, defs;
    logic                  cand_v;
    logic [LABEL_BITS-1:0] cand_lbl;
    logic                  match;
    logic                  cand_new;
    logic                  emit;
    t_out_item             n_out;
    logic [7:0]            rd_reg;
    logic                  rd_is_reg;
    logic                  rd_use;
    logic                  out_free;
    logic                  ld_room;

    assign is_ld  = (r_item.operation == OP_LOAD);
    assign is_ldi = (r_item.operation == OP_LOADI);
    assign is_st  = (r_item.operation == OP_STORE);
    assign is_out = (r_item.operation == OP_OUTPUT);
    assign is_alu = (r_item.operation >= OP_ADD) && (r_item.operation <= OP_RSHIFT);
    assign use1   = is_ld | is_st | is_alu | is_out;
    assign use2   = is_st | is_alu;
    assign defs   = is_ld | is_ldi | is_alu;

    assign out_free = !r_out_v || !i_out_stall;
    assign ld_room  = (int'(r_ld_cnt) < MAX_LOADS);

    assign o_sts.in_nop    = (i_in_data.operation == OP_NOP);
    assign o_sts.out_free  = out_free;
    assign o_sts.walk_more = is_st && (r_li < r_ld_cnt);

    assign rd_reg    = i_cmd.rd1 ? r_item.src1_reg : r_item.src2_reg;
    assign rd_is_reg = i_cmd.rd1 ? r_item.src1_is_reg : r_item.src2_is_reg;
    assign rd_use    = i_cmd.rd1 ? use1 : use2;

    always_comb begin
        case (i_cmd.cand_sel)
            CS_RD: begin
                cand_v   = r_rv;
                cand_lbl = r_rdata;
            end
            CS_LOUT: begin
                cand_v   = (is_out | is_st) & r_lo_v;
                cand_lbl = r_lo;
            end
            CS_LST: begin
                cand_v   = (is_out | is_ld) & r_ls_v;
                cand_lbl = r_ls;
            end
            CS_LOAD: begin
                cand_v   = 1'b1;
                cand_lbl = r_loads[r_li[LD_IW-1:0]];
            end
            default: begin
                cand_v   = 1'b0;
                cand_lbl = '0;
            end
        endcase
    end

    // compare against every label already given for this instruction
    always_comb begin
        match = 1'b0;
        for (int i = 0; i < MAX_EDGES; i++) begin
            if (r_seen_v[i] && (r_seen[i] == cand_lbl)) begin
                match = 1'b1;
            end
        end
    end

    assign cand_new = i_cmd.cand_en && cand_v && !match;

    // a new edge pushes out the one held back; finish flushes with the last mark
    always_comb begin
        emit                     = 1'b0;
        n_out.node_label         = 12'(r_label);
        n_out.has_edge           = 1'b1;
        n_out.predecessor_label  = 12'(r_hold);
        n_out.last_of_run        = 1'b0;
        n_out.load_list_overflow = r_ld_ovf;
        n_out.label_overflow     = r_lbl_ovf;
        if (cand_new && r_hold_v) begin
            emit = 1'b1;
        end
        if (i_cmd.finish) begin
            emit              = 1'b1;
            n_out.last_of_run = 1'b1;
            if (!r_hold_v) begin
                n_out.has_edge          = 1'b0;
                n_out.predecessor_label = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_def_v[i] <= 1'b0;
            end
            for (int i = 0; i < MAX_EDGES; i++) begin
                r_seen_v[i] <= 1'b0;
            end
            r_next   <= (LABEL_BITS + 1)'(1);
            r_lo_v   <= 1'b0;
            r_ls_v   <= 1'b0;
            r_ld_cnt <= '0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cmd.accept && i_in_data.block_start) begin
                for (int i = 0; i < NUM_REGS; i++) begin
                    r_def_v[i] <= 1'b0;
                end
                r_next   <= (LABEL_BITS + 1)'(1);
                r_lo_v   <= 1'b0;
                r_ls_v   <= 1'b0;
                r_ld_cnt <= '0;
            end
            if (i_cmd.label) begin
                if (int'(r_next) <= LABEL_MAX) begin
                    r_next <= r_next + 1'b1;
                end
                for (int i = 0; i < MAX_EDGES; i++) begin
                    r_seen_v[i] <= 1'b0;
                end
                r_hold_v <= 1'b0;
            end
            if (i_cmd.wr_dest && defs && r_item.dest_present && reg_ok(r_item.dest_reg)) begin
                r_def_v[reg_idx(r_item.dest_reg)] <= 1'b1;
            end
            if (cand_new) begin
                r_seen_v[0] <= 1'b1;
                for (int i = 1; i < MAX_EDGES; i++) begin
                    r_seen_v[i] <= r_seen_v[i-1];
                end
                r_hold_v <= 1'b1;
            end
            if (i_cmd.finish) begin
                if (is_out) begin
                    r_lo_v <= 1'b1;
                end
                if (is_ld && ld_room) begin
                    r_ld_cnt <= r_ld_cnt + 1'b1;
                end
                if (is_st) begin
                    r_ls_v   <= 1'b1;
                    r_ld_cnt <= '0;
                end
            end
            if (emit) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // register table: one read or one write a cycle, read data registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_dest && defs && r_item.dest_present && reg_ok(r_item.dest_reg)) begin
            r_mem[reg_idx(r_item.dest_reg)] <= r_label;
        end
        if (i_cmd.rd1 || i_cmd.rd2) begin
            r_rdata <= r_mem[reg_idx(rd_reg)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_in_data;
        end
        if (i_cmd.rd1 || i_cmd.rd2) begin
            r_rv <= rd_use && rd_is_reg && reg_ok(rd_reg) && r_def_v[reg_idx(rd_reg)];
        end
        if (i_cmd.label) begin
            r_lbl_ovf <= (int'(r_next) > LABEL_MAX);
            r_label   <= (int'(r_next) > LABEL_MAX) ? LABEL_BITS'(LABEL_MAX)
                                                    : r_next[LABEL_BITS-1:0];
            r_ld_ovf  <= is_ld && !ld_room;
        end
        if (cand_new) begin
            r_seen[0] <= cand_lbl;
            for (int i = 1; i < MAX_EDGES; i++) begin
                r_seen[i] <= r_seen[i-1];
            end
            r_hold <= cand_lbl;
        end
        if (i_cmd.walk_clr) begin
            r_li <= '0;
        end else if (i_cmd.walk_inc) begin
            r_li <= r_li + 1'b1;
        end
        if (i_cmd.finish) begin
            if (is_out) begin
                r_lo <= r_label;
            end
            if (is_ld && ld_room) begin
                r_loads[r_ld_cnt[LD_IW-1:0]] <= r_label;
            end
            if (is_st) begin
                r_ls <= r_label;
            end
        end
        if (emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule

@@ sv/instruction_dependence_tracker.sv @@
// Top level: builds predecessor edges for the instructions of a basic block.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-------------------------------
//   in      | into      | i_in_valid / o_in_stall   | i_in_data  (one instruction)
//   out     | out of    | o_out_valid / i_out_stall | o_out_data (one predecessor edge)
//
// A nop is taken and gives no result. For any other instruction the
// sequencer walks one candidate edge per cycle, while the output is not
// stalled, through the single-port register table and the pending load
// list (up to 16 pending loads, walked for a store).
// Reset is synchronous, active low; it clears all valid bits at once, so
// there is no clearing pass. The label table itself is never cleared.
// While the result register holds an item under stall, the sequencer waits
// at each edge step; a new instruction is taken as soon as the last result
// is in the result register.
module instruction_dependence_tracker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  idt_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output idt_pkg::t_out_item o_out_data
);
    import idt_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer: one state per candidate edge source
    idt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // tables, duplicate filter and the result register
    idt_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

@@ sv/idt_checker.sv @@
// Port-level checks on the result stream, bound to the top level.
module idt_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_stall,
    input logic               o_out_valid,
    input idt_pkg::t_out_item o_out_data
);
    import idt_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_noedge_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.has_edge |->
            o_out_data.last_of_run && (o_out_data.predecessor_label == 12'd0))
        else $error("edgeless result not alone");

    a_label_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.node_label != 12'd0))
        else $error("zero node label");

    a_edge_earlier: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.has_edge |->
            (o_out_data.predecessor_label != 12'd0) &&
            (o_out_data.predecessor_label <= o_out_data.node_label))
        else $error("edge to a later label");

endmodule

bind instruction_dependence_tracker idt_checker u_idt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_stall (i_out_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data)
);
